>>> design/brc_pkg.sv
// shared types, constants, the sign-extension helper and the axis clip function of the blit rectangle clipper
package brc_pkg;

    localparam int DIM_BITS = 15;
    localparam int OFS_BITS = 2 * DIM_BITS;
    localparam int REQ_BITS = 16;
    // working width for clip arithmetic, wide enough for shifted corners and sums
    localparam int AW = ((DIM_BITS > REQ_BITS) ? DIM_BITS : REQ_BITS) + 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [REQ_BITS-1:0] src_col;
        logic signed [REQ_BITS-1:0] src_row;
        logic signed [REQ_BITS-1:0] width_req;
        logic signed [REQ_BITS-1:0] height_req;
        logic signed [REQ_BITS-1:0] dst_col;
        logic signed [REQ_BITS-1:0] dst_row;
        logic                       same_surface;
    } t_req;

    typedef struct packed {
        logic                nothing_to_copy;
        logic                copy_backward;
        logic [DIM_BITS-1:0] clip_src_col;
        logic [DIM_BITS-1:0] clip_src_row;
        logic [DIM_BITS-1:0] clip_dst_col;
        logic [DIM_BITS-1:0] clip_dst_row;
        logic [DIM_BITS-1:0] clip_width;
        logic [DIM_BITS-1:0] clip_height;
        logic [OFS_BITS-1:0] src_offset;
        logic [OFS_BITS-1:0] dst_offset;
    } t_res;

    // clipped rectangle handed from the clip stages to the offset stages
    typedef struct packed {
        logic                ok;
        logic                same;
        logic [DIM_BITS-1:0] sx;
        logic [DIM_BITS-1:0] sy;
        logic [DIM_BITS-1:0] dx;
        logic [DIM_BITS-1:0] dy;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } t_clip;

    typedef struct packed {
        logic                 ok;
        logic signed [AW-1:0] pos;
        logic signed [AW-1:0] other;
        logic signed [AW-1:0] size;
    } t_axis;

    function automatic logic signed [AW-1:0] sext_req(input logic signed [REQ_BITS-1:0] v);
        sext_req = {{(AW-REQ_BITS){v[REQ_BITS-1]}}, v};
    endfunction

    // clip one axis: far edge against the extent, then a negative start
    function automatic t_axis clip_axis(
        input logic signed [AW-1:0] pos,
        input logic signed [AW-1:0] other,
        input logic signed [AW-1:0] size,
        input logic [DIM_BITS-1:0]  extent
    );
        t_axis               r;
        logic signed [AW-1:0] sum;
        logic signed [AW-1:0] ext_s;
        ext_s   = $signed({{(AW-DIM_BITS){1'b0}}, extent});
        r.pos   = pos;
        r.other = other;
        r.size  = size;
        r.ok    = (size > 0);
        sum     = pos + size;
        if (sum > ext_s) begin
            r.size = ext_s - pos;
        end
        if (r.size <= 0) begin
            r.ok = 1'b0;
        end
        if (pos < 0) begin
            r.other = other - pos;
            r.size  = r.size + pos;
            r.pos   = '0;
        end
        if (r.size <= 0) begin
            r.ok = 1'b0;
        end
        clip_axis = r;
    endfunction

endpackage

>>> design/brc_if.sv
// request and result channel interfaces of the blit rectangle clipper
interface brc_req_if import brc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface brc_res_if import brc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/brc_offset.sv
// offset stages: row times surface width, column add, direction and output register
module brc_offset import brc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_clip               i_stg,
    input  logic [DIM_BITS-1:0] i_src_w,
    input  logic [DIM_BITS-1:0] i_dst_w,
    output logic                o_adv,
    brc_res_if.source           o_res
);

    logic                r_s3_valid;
    t_clip               r_s3;
    logic [OFS_BITS-1:0] r_src_prod;
    logic [OFS_BITS-1:0] r_dst_prod;
    logic                r_out_valid;
    t_res                r_res;

    logic [OFS_BITS-1:0] n_so;
    logic [OFS_BITS-1:0] n_dof;
    t_res                n_res;

    // whole pipe moves when the output register is free or being drained
    assign o_adv = !r_out_valid || o_res.ready;

    // stage 3 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (o_adv) begin
            r_s3_valid <= i_valid;
        end
    end

    // stage 3: row products
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s3       <= i_stg;
            r_src_prod <= OFS_BITS'(i_stg.sy) * OFS_BITS'(i_src_w);
            r_dst_prod <= OFS_BITS'(i_stg.dy) * OFS_BITS'(i_dst_w);
        end
    end

    // stage 4: add columns, pick direction, blank an empty rectangle
    always_comb begin
        n_so  = r_src_prod + {{(OFS_BITS-DIM_BITS){1'b0}}, r_s3.sx};
        n_dof = r_dst_prod + {{(OFS_BITS-DIM_BITS){1'b0}}, r_s3.dx};
        n_res = '0;
        if (r_s3.ok) begin
            n_res.copy_backward = r_s3.same && (n_so <= n_dof);
            n_res.clip_src_col  = r_s3.sx;
            n_res.clip_src_row  = r_s3.sy;
            n_res.clip_dst_col  = r_s3.dx;
            n_res.clip_dst_row  = r_s3.dy;
            n_res.clip_width    = r_s3.w;
            n_res.clip_height   = r_s3.h;
            n_res.src_offset    = n_so;
            n_res.dst_offset    = n_dof;
        end else begin
            n_res.nothing_to_copy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // an empty beat carries zeros only
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.nothing_to_copy |->
            !r_res.copy_backward && r_res.clip_width == '0 && r_res.clip_height == '0
            && r_res.src_offset == '0 && r_res.dst_offset == '0)
        else $error("empty result carries non-zero fields");

    // a non-empty beat has a real size
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.nothing_to_copy |->
            r_res.clip_width != '0 && r_res.clip_height != '0)
        else $error("non-empty result with zero size");

    // clipped source span stays inside the source surface
    a_src_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.nothing_to_copy |->
            ({1'b0, r_res.clip_src_col} + {1'b0, r_res.clip_width}) <= {1'b0, i_src_w})
        else $error("clipped source span exceeds surface width");

    // clipped destination span stays inside the destination surface
    a_dst_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.nothing_to_copy |->
            ({1'b0, r_res.clip_dst_col} + {1'b0, r_res.clip_width}) <= {1'b0, i_dst_w})
        else $error("clipped destination span exceeds surface width");

endmodule

>>> design/blit_rect_clip_direction_top.sv
// top level of the blit rectangle clipper: config registers, the two clip stages and the offset stages
// a request passes the stage 1, stage 2, stage 3 and output registers on its way to its result beat
// throughput: one request per cycle while the output is not stalled; the four register stages advance together
// a stalled output holds every stage, so nothing is dropped or repeated
// reset: synchronous active low, clears all valid bits and the surface size registers to zero
// surface sizes are read live and must only change while the pipe is empty
module blit_rect_clip_direction_top import brc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [DIM_BITS-1:0] i_cfg_data,
    brc_req_if.sink             i_req,
    brc_res_if.source           o_res
);

    logic [DIM_BITS-1:0] r_src_w;
    logic [DIM_BITS-1:0] r_src_h;
    logic [DIM_BITS-1:0] r_dst_w;
    logic [DIM_BITS-1:0] r_dst_h;

    logic                 w_adv;
    logic                 r_s1_valid;
    logic                 r_s1_ok;
    logic                 r_s1_same;
    logic signed [AW-1:0] r_s1_sx;
    logic signed [AW-1:0] r_s1_sy;
    logic signed [AW-1:0] r_s1_dx;
    logic signed [AW-1:0] r_s1_dy;
    logic signed [AW-1:0] r_s1_w;
    logic signed [AW-1:0] r_s1_h;
    logic                 r_s2_valid;
    t_clip                r_s2;

    t_axis n_src_x;
    t_axis n_src_y;
    t_axis n_dst_x;
    t_axis n_dst_y;
    t_clip n_s2;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= '0;
            r_src_h <= '0;
            r_dst_w <= '0;
            r_dst_h <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = w_adv;

    // stage 1: clip both axes against the source surface
    always_comb begin
        n_src_x = clip_axis(sext_req(i_req.data.src_col), sext_req(i_req.data.dst_col),
                            sext_req(i_req.data.width_req), r_src_w);
        n_src_y = clip_axis(sext_req(i_req.data.src_row), sext_req(i_req.data.dst_row),
                            sext_req(i_req.data.height_req), r_src_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ok   <= n_src_x.ok && n_src_y.ok;
            r_s1_same <= i_req.data.same_surface;
            r_s1_sx   <= n_src_x.pos;
            r_s1_dx   <= n_src_x.other;
            r_s1_w    <= n_src_x.size;
            r_s1_sy   <= n_src_y.pos;
            r_s1_dy   <= n_src_y.other;
            r_s1_h    <= n_src_y.size;
        end
    end

    // stage 2: clip both axes against the destination surface, source moves along
    always_comb begin
        n_dst_x   = clip_axis(r_s1_dx, r_s1_sx, r_s1_w, r_dst_w);
        n_dst_y   = clip_axis(r_s1_dy, r_s1_sy, r_s1_h, r_dst_h);
        n_s2.ok   = r_s1_ok && n_dst_x.ok && n_dst_y.ok;
        n_s2.same = r_s1_same;
        n_s2.dx   = n_dst_x.pos[DIM_BITS-1:0];
        n_s2.sx   = n_dst_x.other[DIM_BITS-1:0];
        n_s2.w    = n_dst_x.size[DIM_BITS-1:0];
        n_s2.dy   = n_dst_y.pos[DIM_BITS-1:0];
        n_s2.sy   = n_dst_y.other[DIM_BITS-1:0];
        n_s2.h    = n_dst_y.size[DIM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2 <= n_s2;
        end
    end

    // stages 3 and 4: offsets, direction and output register
    brc_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_stg   (r_s2),
        .i_src_w (r_src_w),
        .i_dst_w (r_dst_w),
        .o_adv   (w_adv),
        .o_res   (o_res)
    );

endmodule
